// File: rtl/tph_pkg.sv
// Package: shared constants and helpers for the triangle plane height pipeline.
`default_nettype none

package tph_pkg;

  // Operand slice width that one multiplier stage consumes per cycle.
  localparam int MUL_PIECE = 16;

  // Number of register stages a multiplier needs for an operand of this width.
  function automatic int mul_stages(input int width);
    return (width + MUL_PIECE - 1) / MUL_PIECE;
  endfunction

endpackage

`default_nettype wire

// File: rtl/tph_in_if.sv
// Interface: input channel carrying one triangle and one query point per word.
`default_nettype none

interface tph_in_if #(
  parameter int W = 32
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] vert0_x;
  logic signed [W-1:0] vert0_y;
  logic signed [W-1:0] vert0_z;
  logic signed [W-1:0] vert1_x;
  logic signed [W-1:0] vert1_y;
  logic signed [W-1:0] vert1_z;
  logic signed [W-1:0] vert2_x;
  logic signed [W-1:0] vert2_y;
  logic signed [W-1:0] vert2_z;
  logic signed [W-1:0] point_x;
  logic signed [W-1:0] point_z;

  modport source (
    output valid, vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z,
           vert2_x, vert2_y, vert2_z, point_x, point_z,
    input  ready
  );

  modport sink (
    input  valid, vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z,
           vert2_x, vert2_y, vert2_z, point_x, point_z,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/tph_out_if.sv
// Interface: result channel carrying one height word.
`default_nettype none

interface tph_out_if #(
  parameter int W = 32
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] height;
  logic                degenerate;
  logic                saturated;

  modport source (
    output valid, height, degenerate, saturated,
    input  ready
  );

  modport sink (
    input  valid, height, degenerate, saturated,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/tph_mul.sv
// Pipelined signed multiplier: one operand slice times the other operand per stage.
`default_nettype none

module tph_mul
  import tph_pkg::*;
#(
  parameter int WA = 33,
  parameter int WB = 33
) (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic signed [WA-1:0]    a,
  input  wire logic signed [WB-1:0]    b,
  output      logic signed [WA+WB-1:0] p
);

  localparam int NP = mul_stages(WA);
  localparam int WP = WA + WB;
  localparam int WX = NP * MUL_PIECE;

  logic signed [WX-1:0] a_ext;
  logic signed [WX-1:0] a_r   [NP-1];
  logic signed [WB-1:0] b_r   [NP-1];
  logic signed [WP-1:0] acc_r [NP];

  assign a_ext = WX'(a);

  for (genvar s = 0; s < NP; s++) begin : g_stage
    logic signed [WX-1:0]          a_src;
    logic signed [WB-1:0]          b_src;
    logic signed [WP-1:0]          acc_src;
    logic        [MUL_PIECE-1:0]   piece;
    logic signed [MUL_PIECE:0]     piece_x;
    logic signed [MUL_PIECE+WB:0]  pp;
    logic signed [WP-1:0]          pp_x;

    if (s == 0) begin : g_first
      assign a_src   = a_ext;
      assign b_src   = b;
      assign acc_src = '0;
    end else begin : g_next
      assign a_src   = a_r[s-1];
      assign b_src   = b_r[s-1];
      assign acc_src = acc_r[s-1];
    end

    assign piece = a_src[s*MUL_PIECE +: MUL_PIECE];

    // top slice carries the sign, lower slices are unsigned
    if (s == NP - 1) begin : g_top
      assign piece_x = {piece[MUL_PIECE-1], piece};
    end else begin : g_low
      assign piece_x = {1'b0, piece};
    end

    assign pp   = piece_x * b_src;
    assign pp_x = WP'(pp);

    always_ff @(posedge clk) begin
      if (en) begin
        acc_r[s] <= acc_src + (pp_x <<< (s * MUL_PIECE));
      end
    end

    if (s < NP - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          a_r[s] <= a_src;
          b_r[s] <= b_src;
        end
      end
    end
  end

  assign p = acc_r[NP-1];

endmodule

`default_nettype wire

// File: rtl/tph_delay.sv
// Delay line: valid bit and side data matched to a datapath's latency.
`default_nettype none

module tph_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         en,
  input  wire logic         in_vld,
  input  wire logic [W-1:0] in_data,
  output      logic         out_vld,
  output      logic [W-1:0] out_data
);

  logic [DEPTH-1:0] vld_r;
  logic [W-1:0]     dat_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dat_r[0] <= in_data;
      for (int i = 1; i < DEPTH; i++) begin
        dat_r[i] <= dat_r[i-1];
      end
    end
  end

  assign out_vld  = vld_r[DEPTH-1];
  assign out_data = dat_r[DEPTH-1];

endmodule

`default_nettype wire

// File: rtl/tph_div.sv
// Pipelined restoring divider: one quotient bit per stage, overflow flag on a wide quotient.
`default_nettype none

module tph_div #(
  parameter int WN = 103,
  parameter int WD = 68,
  parameter int Q  = 33
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [WN-1:0] n,
  input  wire logic [WD-1:0] d,
  output      logic [Q-1:0]  q,
  output      logic          ovf
);

  localparam int WH = WN - Q;

  logic [WH-1:0] n_hi;
  logic [WD-1:0] r_r   [Q];
  logic [Q-1:0]  low_r [Q];
  logic [WD-1:0] d_r   [Q];
  logic [Q-1:0]  q_r   [1:Q];
  logic          ovf_r [Q+1];

  assign n_hi = n[WN-1:Q];

  // quotient needs more than Q bits when the upper numerator reaches the divisor
  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0]   <= n_hi[WD-1:0];
      low_r[0] <= n[Q-1:0];
      d_r[0]   <= d;
      ovf_r[0] <= (n_hi >= WH'(d));
    end
  end

  for (genvar k = 1; k <= Q; k++) begin : g_step
    logic [WD:0]   r_sh;
    logic [WD+1:0] diff;
    logic          ge;
    logic [Q-1:0]  q_src;

    assign r_sh = {r_r[k-1], low_r[k-1][Q-k]};
    assign diff = {1'b0, r_sh} - {2'b00, d_r[k-1]};
    assign ge   = !diff[WD+1];

    if (k == 1) begin : g_first
      assign q_src = '0;
    end else begin : g_next
      assign q_src = q_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k]   <= {q_src[Q-2:0], ge};
        ovf_r[k] <= ovf_r[k-1];
      end
    end

    if (k < Q) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          r_r[k]   <= ge ? diff[WD-1:0] : r_sh[WD-1:0];
          low_r[k] <= low_r[k-1];
          d_r[k]   <= d_r[k-1];
        end
      end
    end
  end

  assign q   = q_r[Q];
  assign ovf = ovf_r[Q];

endmodule

`default_nettype wire

// File: rtl/triangle_plane_height_top.sv
// Top level: triangle plane height interpolation pipeline.
//
// in_bus carries one word per triangle query: three vertices and a point
// (x, z), all signed fixed point of COORD_WIDTH bits. out_bus returns one
// word per query: the height on the triangle's plane at (x, z) plus the
// height_offset register, saturated to COORD_WIDTH bits, with degenerate
// set (height 0) when the plane normal has no y component.
// cfg_we / cfg_wdata write height_offset; reset loads 0.5 in FRAC_BITS.
//
// Throughput: one word per cycle while out_bus.ready is not held off.
// Latency from acceptance to out_bus.valid is set by the sliced normal and
// numerator multipliers and by the divider, which retires one quotient bit
// per stage.
//
// Reset clears every valid bit; no words are in flight afterwards. When the
// receiver holds off out_bus.ready with a word waiting, the whole pipeline
// freezes and in_bus.ready drops in the same cycle; nothing is lost.
`default_nettype none

module triangle_plane_height_top
  import tph_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  tph_in_if.sink                      in_bus,
  tph_out_if.source                   out_bus,
  input  wire logic                   cfg_we,
  input  wire logic [COORD_WIDTH-1:0] cfg_wdata
);

  localparam int C    = COORD_WIDTH;
  localparam int E    = C + 1;
  localparam int NW   = 2 * E + 1;
  localparam int NUMW = NW + E + 1;
  localparam int NNW  = NUMW + 2;
  localparam int DW   = NW + 1;
  localparam int Q    = C + 1;
  localparam int LN   = mul_stages(E);
  localparam int LM   = mul_stages(NW);
  localparam int SW1  = 2 * E + C + 1;
  localparam int SW2  = NW + C + 1;
  localparam int SW3  = C + 3;

  localparam logic [C-1:0] OFFSET_RST = C'(1) << (FRAC_BITS - 1);

  logic en;

  // configuration
  logic signed [C-1:0] offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= OFFSET_RST;
    end else if (cfg_we) begin
      offset_r <= cfg_wdata;
    end
  end

  // stage 0: edge vectors, point deltas, base height
  logic signed [E-1:0] x0, y0, z0;
  logic signed [E-1:0] s0_ax_r, s0_ay_r, s0_az_r, s0_bx_r, s0_by_r, s0_bz_r;
  logic signed [E-1:0] s0_dx_r, s0_dz_r;
  logic signed [C:0]   s0_base_r;
  logic                s0_v_r;

  assign x0 = E'(in_bus.vert0_x);
  assign y0 = E'(in_bus.vert0_y);
  assign z0 = E'(in_bus.vert0_z);

  assign en           = !out_bus.valid || out_bus.ready;
  assign in_bus.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_ax_r   <= x0 - E'(in_bus.vert1_x);
      s0_ay_r   <= y0 - E'(in_bus.vert1_y);
      s0_az_r   <= z0 - E'(in_bus.vert1_z);
      s0_bx_r   <= x0 - E'(in_bus.vert2_x);
      s0_by_r   <= y0 - E'(in_bus.vert2_y);
      s0_bz_r   <= z0 - E'(in_bus.vert2_z);
      s0_dx_r   <= E'(in_bus.point_x) - x0;
      s0_dz_r   <= E'(in_bus.point_z) - z0;
      s0_base_r <= (C+1)'(in_bus.vert0_y) + (C+1)'(offset_r);
    end
  end

  // normal: six cross-product terms in parallel
  logic signed [E-1:0]   ma [6];
  logic signed [E-1:0]   mb [6];
  logic signed [2*E-1:0] mp [6];

  assign ma[0] = s0_ay_r;  assign mb[0] = s0_bz_r;
  assign ma[1] = s0_az_r;  assign mb[1] = s0_by_r;
  assign ma[2] = s0_az_r;  assign mb[2] = s0_bx_r;
  assign ma[3] = s0_ax_r;  assign mb[3] = s0_bz_r;
  assign ma[4] = s0_ax_r;  assign mb[4] = s0_by_r;
  assign ma[5] = s0_ay_r;  assign mb[5] = s0_bx_r;

  for (genvar i = 0; i < 6; i++) begin : g_nmul
    tph_mul #(.WA(E), .WB(E)) u_mul (
      .clk (clk),
      .en  (en),
      .a   (ma[i]),
      .b   (mb[i]),
      .p   (mp[i])
    );
  end

  logic           d1_v;
  logic [SW1-1:0] d1_data;

  tph_delay #(.W(SW1), .DEPTH(LN)) u_dly1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s0_v_r),
    .in_data  ({s0_dx_r, s0_dz_r, s0_base_r}),
    .out_vld  (d1_v),
    .out_data (d1_data)
  );

  // stage 1: normal components
  logic signed [NW-1:0] s1_nx_r, s1_ny_r, s1_nz_r;
  logic signed [E-1:0]  s1_dx_r, s1_dz_r;
  logic signed [C:0]    s1_base_r;
  logic                 s1_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= d1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_nx_r   <= NW'(mp[0]) - NW'(mp[1]);
      s1_ny_r   <= NW'(mp[2]) - NW'(mp[3]);
      s1_nz_r   <= NW'(mp[4]) - NW'(mp[5]);
      s1_dx_r   <= d1_data[SW1-1 -: E];
      s1_dz_r   <= d1_data[SW1-1-E -: E];
      s1_base_r <= d1_data[C:0];
    end
  end

  // numerator terms
  logic signed [NW+E-1:0] px, pz;

  tph_mul #(.WA(NW), .WB(E)) u_mul_x (
    .clk (clk),
    .en  (en),
    .a   (s1_nx_r),
    .b   (s1_dx_r),
    .p   (px)
  );

  tph_mul #(.WA(NW), .WB(E)) u_mul_z (
    .clk (clk),
    .en  (en),
    .a   (s1_nz_r),
    .b   (s1_dz_r),
    .p   (pz)
  );

  logic           d2_v;
  logic [SW2-1:0] d2_data;

  tph_delay #(.W(SW2), .DEPTH(LM)) u_dly2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s1_v_r),
    .in_data  ({s1_ny_r, s1_base_r}),
    .out_vld  (d2_v),
    .out_data (d2_data)
  );

  // stage 2: numerator sum
  logic signed [NUMW-1:0] s2_num_r;
  logic signed [NW-1:0]   s2_ny_r;
  logic signed [C:0]      s2_base_r;
  logic                   s2_v_r;

  // stage 3: magnitudes and signs
  logic [NUMW-1:0] s3_anum_r;
  logic [NW-1:0]   s3_any_r;
  logic            s3_neg_r, s3_degen_r;
  logic [C:0]      s3_base_r;
  logic            s3_v_r;

  // stage 4: rounded division operands
  logic [NNW-1:0]  s4_n_r;
  logic [DW-1:0]   s4_d_r;
  logic            s4_neg_r, s4_degen_r;
  logic [C:0]      s4_base_r;
  logic            s4_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= d2_v;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_num_r   <= NUMW'(px) + NUMW'(pz);
      s2_ny_r    <= d2_data[SW2-1 -: NW];
      s2_base_r  <= d2_data[C:0];

      s3_anum_r  <= s2_num_r[NUMW-1] ? -s2_num_r : s2_num_r;
      s3_any_r   <= s2_ny_r[NW-1] ? -s2_ny_r : s2_ny_r;
      // quotient is negated when numerator and normal y share a sign
      s3_neg_r   <= (s2_num_r[NUMW-1] == s2_ny_r[NW-1]);
      s3_degen_r <= (s2_ny_r == '0);
      s3_base_r  <= s2_base_r;

      s4_n_r     <= NNW'({s3_anum_r, 1'b0}) + NNW'(s3_any_r);
      s4_d_r     <= {s3_any_r, 1'b0};
      s4_neg_r   <= s3_neg_r;
      s4_degen_r <= s3_degen_r;
      s4_base_r  <= s3_base_r;
    end
  end

  // division
  logic [Q-1:0] dq;
  logic         dovf;

  tph_div #(.WN(NNW), .WD(DW), .Q(Q)) u_div (
    .clk (clk),
    .en  (en),
    .n   (s4_n_r),
    .d   (s4_d_r),
    .q   (dq),
    .ovf (dovf)
  );

  logic           d3_v;
  logic [SW3-1:0] d3_data;

  tph_delay #(.W(SW3), .DEPTH(Q + 1)) u_dly3 (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s4_v_r),
    .in_data  ({s4_neg_r, s4_degen_r, s4_base_r}),
    .out_vld  (d3_v),
    .out_data (d3_data)
  );

  // stage 5: signed quotient, clamped to a magnitude that always saturates
  logic [Q:0]          mag;
  logic [Q+1:0]        mag_x;
  logic signed [Q+1:0] s5_smag_r;
  logic signed [C:0]   s5_base_r;
  logic                s5_degen_r;
  logic                s5_v_r;

  assign mag   = dovf ? {1'b1, Q'(0)} : {1'b0, dq};
  assign mag_x = {1'b0, mag};

  // stage 6: height before saturation
  logic signed [C+3:0] s6_h_r;
  logic                s6_degen_r;
  logic                s6_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
    end else if (en) begin
      s5_v_r <= d3_v;
      s6_v_r <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_smag_r  <= d3_data[SW3-1] ? -mag_x : mag_x;
      s5_degen_r <= d3_data[SW3-2];
      s5_base_r  <= d3_data[C:0];

      s6_h_r     <= (C+4)'(s5_base_r) + (C+4)'(s5_smag_r);
      s6_degen_r <= s5_degen_r;
    end
  end

  // output register with saturation
  logic                in_range;
  logic                out_valid_r;
  logic signed [C-1:0] out_height_r;
  logic                out_degen_r, out_sat_r;

  assign in_range = (s6_h_r[C+3:C-1] == '0) || (s6_h_r[C+3:C-1] == '1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s6_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (s6_degen_r) begin
        out_height_r <= '0;
        out_degen_r  <= 1'b1;
        out_sat_r    <= 1'b0;
      end else if (in_range) begin
        out_height_r <= s6_h_r[C-1:0];
        out_degen_r  <= 1'b0;
        out_sat_r    <= 1'b0;
      end else begin
        out_height_r <= s6_h_r[C+3] ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};
        out_degen_r  <= 1'b0;
        out_sat_r    <= 1'b1;
      end
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.height     = out_height_r;
  assign out_bus.degenerate = out_degen_r;
  assign out_bus.saturated  = out_sat_r;

endmodule

`default_nettype wire

// File: rtl/tph_checker.sv
// Checker: port-level properties of the triangle plane height block, bound to the top.
`default_nettype none

module tph_checker #(
  parameter int COORD_WIDTH = 32
) (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_ready,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [COORD_WIDTH-1:0] out_height,
  input wire logic                   out_degenerate,
  input wire logic                   out_saturated
);

  localparam logic [COORD_WIDTH-1:0] H_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] H_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // no word survives reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word present after reset");

  // input side stalls exactly when a result word is held
  a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not track output stall");

  // degenerate words carry zero height and no clip
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_height == '0 && !out_saturated)
    else $error("degenerate word with nonzero height or saturation");

  // clipped words sit on a range bound
  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> out_height == H_MAX || out_height == H_MIN)
    else $error("saturated word not at a range bound");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_height))
    else $error("stalled result word changed");

endmodule

bind triangle_plane_height_top tph_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_tph_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_bus.ready),
  .out_valid      (out_bus.valid),
  .out_ready      (out_bus.ready),
  .out_height     (out_bus.height),
  .out_degenerate (out_bus.degenerate),
  .out_saturated  (out_bus.saturated)
);

`default_nettype wire

// File: test/tph_height_checker.sv
`timescale 1ns / 1ps
// Checker: predicts the height word of each accepted triangle query and compares the results.
module tph_height_checker (
  input  logic        clk,
  input  logic        rst_n,
  tph_in_if           in_mon,
  tph_out_if          out_mon,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  output int          fail_count,
  output int          pending,
  output int          word_count,
  output int          degenerate_count,
  output int          saturated_count
);

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic [31:0] v0x, v0y, v0z;
    logic [31:0] v1x, v1y, v1z;
    logic [31:0] v2x, v2y, v2z;
    logic [31:0] px, pz;
  } tri_t;

  typedef struct packed {
    logic signed [31:0] height;
    logic               degenerate;
    logic               saturated;
  } height_word_t;

  localparam wide_t       HEIGHT_MAX   = 128'sd2147483647;
  localparam wide_t       HEIGHT_MIN   = -128'sd2147483648;
  localparam logic [31:0] OFFSET_RESET = 32'h0000_8000;

  logic [31:0]  height_offset;
  height_word_t expected_heights [$];

  function automatic wide_t widen(input logic [31:0] v);
    return {{96{v[31]}}, v};
  endfunction

  // exact plane solve, quotient rounded half away from zero, then clipped
  function automatic height_word_t predict_plane_height(input tri_t q,
                                                         input logic [31:0] offset);
    wide_t x0, y0, z0, ax, ay, az, bx, by, bz, nx, ny, nz;
    wide_t num, num_mag, ny_mag, mag, h;
    height_word_t w;
    x0 = widen(q.v0x);
    y0 = widen(q.v0y);
    z0 = widen(q.v0z);
    ax = x0 - widen(q.v1x);
    ay = y0 - widen(q.v1y);
    az = z0 - widen(q.v1z);
    bx = x0 - widen(q.v2x);
    by = y0 - widen(q.v2y);
    bz = z0 - widen(q.v2z);
    nx = ay * bz - az * by;
    ny = az * bx - ax * bz;
    nz = ax * by - ay * bx;
    w.height     = '0;
    w.degenerate = 1'b0;
    w.saturated  = 1'b0;
    if (ny == 0) begin
      w.degenerate = 1'b1;
      return w;
    end
    num     = nx * (widen(q.px) - x0) + nz * (widen(q.pz) - z0);
    num_mag = (num < 0) ? -num : num;
    ny_mag  = (ny < 0) ? -ny : ny;
    mag     = (num_mag * 2 + ny_mag) / (ny_mag * 2);
    if ((num < 0) == (ny < 0)) begin
      mag = -mag;
    end
    h = y0 + widen(offset) + mag;
    if (h > HEIGHT_MAX) begin
      h = HEIGHT_MAX;
      w.saturated = 1'b1;
    end else if (h < HEIGHT_MIN) begin
      h = HEIGHT_MIN;
      w.saturated = 1'b1;
    end
    w.height = h[31:0];
    return w;
  endfunction

  always @(posedge clk) begin
    tri_t         q;
    height_word_t want;
    height_word_t got;
    if (!rst_n) begin
      height_offset <= OFFSET_RESET;
      expected_heights.delete();
      fail_count       <= 0;
      pending          <= 0;
      word_count       <= 0;
      degenerate_count <= 0;
      saturated_count  <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.height, out_mon.degenerate, out_mon.saturated};
        if (expected_heights.size() == 0) begin
          fail_count <= fail_count + 1;
          $display("%0t: unexpected height word: expected none, got height %h degenerate %b saturated %b",
                   $time, got.height, got.degenerate, got.saturated);
        end else begin
          want = expected_heights.pop_front();
          word_count       <= word_count + 1;
          degenerate_count <= degenerate_count + want.degenerate;
          saturated_count  <= saturated_count + want.saturated;
          if (got !== want) begin
            fail_count <= fail_count + 1;
            $display({"%0t: height word mismatch: expected height %h degenerate %b ",
                      "saturated %b, got height %h degenerate %b saturated %b"},
                     $time, want.height, want.degenerate, want.saturated,
                     got.height, got.degenerate, got.saturated);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        q = '{in_mon.vert0_x, in_mon.vert0_y, in_mon.vert0_z,
              in_mon.vert1_x, in_mon.vert1_y, in_mon.vert1_z,
              in_mon.vert2_x, in_mon.vert2_y, in_mon.vert2_z,
              in_mon.point_x, in_mon.point_z};
        expected_heights.push_back(predict_plane_height(q, height_offset));
      end
      if (cfg_we) begin
        height_offset <= cfg_wdata;
      end
      pending <= expected_heights.size();
    end
  end

endmodule

// File: test/tb_triangle_plane_height_top.sv
`timescale 1ns / 1ps
// Testbench top: drives triangle queries and offset writes into the height block and gives the verdict.
module tb_triangle_plane_height_top;

  typedef struct packed {
    logic [31:0] v0x, v0y, v0z;
    logic [31:0] v1x, v1y, v1z;
    logic [31:0] v2x, v2y, v2z;
    logic [31:0] px, pz;
  } tri_t;

  localparam logic [31:0] ONE         = 32'h0001_0000;
  localparam logic [31:0] HALF        = 32'h0000_8000;
  localparam logic [31:0] QMAX        = 32'h7fff_ffff;
  localparam logic [31:0] QMIN        = 32'h8000_0000;
  localparam int          PHASES      = 6;
  localparam int          PHASE_ITEMS = 175;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          DRAIN       = 60;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  bit          calm;
  int          sent;
  int          offsets_written;
  int          cycles;
  int          fail_count;
  int          pending;
  int          word_count;
  int          degenerate_count;
  int          saturated_count;

  tph_in_if  #(.W(32)) in_bus ();
  tph_out_if #(.W(32)) out_bus ();

  triangle_plane_height_top #(
    .COORD_WIDTH (32),
    .FRAC_BITS   (16)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  tph_height_checker u_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_mon           (in_bus),
    .out_mon          (out_bus),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .fail_count       (fail_count),
    .pending          (pending),
    .word_count       (word_count),
    .degenerate_count (degenerate_count),
    .saturated_count  (saturated_count)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic tri_t triangle(input logic [31:0] v0x, v0y, v0z, v1x, v1y, v1z,
                                    input logic [31:0] v2x, v2y, v2z, px, pz);
    return '{v0x, v0y, v0z, v1x, v1y, v1z, v2x, v2y, v2z, px, pz};
  endfunction

  function automatic logic [31:0] spread(input logic [31:0] center, input int span);
    logic [31:0] r;
    r = $urandom & ((32'd1 << span) - 1);
    return center + r - (32'd1 << (span - 1));
  endfunction

  function automatic logic [31:0] extreme_value();
    case ($urandom_range(0, 5))
      0: return QMAX;
      1: return QMIN;
      2: return 32'h0;
      3: return 32'hffff_ffff;
      4: return 32'h1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] headroom_base();
    return $signed($urandom) >>> 2;
  endfunction

  function automatic tri_t random_query();
    tri_t        q;
    logic [31:0] bx, by, bz, dx, dz;
    int          span, k, kind;
    kind = $urandom_range(0, 19);
    bx = headroom_base();
    by = headroom_base();
    bz = headroom_base();
    if (kind < 10) begin
      // small terrain triangle with the point nearby
      span = $urandom_range(4, 24);
      q = triangle(spread(bx, span), spread(by, span), spread(bz, span),
                   spread(bx, span), spread(by, span), spread(bz, span),
                   spread(bx, span), spread(by, span), spread(bz, span),
                   spread(bx, span + 1), spread(bz, span + 1));
    end else if (kind < 13) begin
      // edges parallel in xz: normal has no y part
      dx = spread(32'h0, 12);
      dz = spread(32'h0, 12);
      k  = $urandom_range(0, 4) - 2;
      q = triangle(bx, $urandom, bz, bx + dx, $urandom, bz + dz,
                   bx + k * dx, $urandom, bz + k * dz, $urandom, $urandom);
    end else if (kind < 16) begin
      q = triangle(extreme_value(), extreme_value(), extreme_value(),
                   extreme_value(), extreme_value(), extreme_value(),
                   extreme_value(), extreme_value(), extreme_value(),
                   extreme_value(), extreme_value());
    end else begin
      q = triangle($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom, $urandom);
    end
    return q;
  endfunction

  task automatic send_query(input tri_t q);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.vert0_x <= q.v0x;
    in_bus.vert0_y <= q.v0y;
    in_bus.vert0_z <= q.v0z;
    in_bus.vert1_x <= q.v1x;
    in_bus.vert1_y <= q.v1y;
    in_bus.vert1_z <= q.v1z;
    in_bus.vert2_x <= q.v2x;
    in_bus.vert2_y <= q.v2y;
    in_bus.vert2_z <= q.v2z;
    in_bus.point_x <= q.px;
    in_bus.point_z <= q.pz;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
    sent++;
  endtask

  // offset only changes with the pipeline empty
  task automatic set_height_offset(input logic [31:0] value);
    in_bus.valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    offsets_written++;
  endtask

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    int stall;
    out_bus.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
      @(negedge clk);
    end
  end

  initial begin
    logic [31:0] offsets [PHASES];
    int          p;
    int          n;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    calm           = 1'b0;
    sent           = 0;
    offsets_written = 0;
    in_bus.valid   = 1'b0;
    in_bus.vert0_x = '0;
    in_bus.vert0_y = '0;
    in_bus.vert0_z = '0;
    in_bus.vert1_x = '0;
    in_bus.vert1_y = '0;
    in_bus.vert1_z = '0;
    in_bus.vert2_x = '0;
    in_bus.vert2_y = '0;
    in_bus.vert2_z = '0;
    in_bus.point_x = '0;
    in_bus.point_z = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed words, offset still at its reset value
    send_query(triangle(0, 0, 0, ONE, 0, 0, 0, 0, ONE, HALF, HALF));
    send_query(triangle(0, 2 * ONE, 0, ONE, 3 * ONE, 0, 0, 2 * ONE, ONE, ONE / 4, 3 * HALF));
    send_query(triangle(0, 0, 0, -32'd2, 0, 0, 0, -32'd3, -32'd2, 0, 32'd1));
    send_query(triangle(0, 0, 0, -32'd2, 0, 0, 0, -32'd3, -32'd2, 0, -32'd1));
    send_query(triangle(ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, 3 * ONE, -ONE));
    send_query(triangle(0, 0, 0, ONE, 5 * ONE, ONE, 2 * ONE, -ONE, 2 * ONE, ONE, ONE));
    send_query(triangle(0, QMAX, 0, ONE, QMAX, 0, 0, QMAX, ONE, HALF, HALF));
    send_query(triangle(0, QMIN, 0, ONE, QMIN + ONE, 0, 0, QMIN, ONE, -8 * ONE, 0));
    send_query(triangle(QMAX, QMAX, QMAX, QMIN, QMIN, QMIN, QMIN, QMAX, QMAX, QMIN, QMAX));
    send_query(triangle(QMIN, QMIN, QMIN, QMAX, QMAX, QMAX, QMAX, QMIN, QMIN, QMAX, QMIN));
    send_query(triangle(QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX));
    send_query(triangle('1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1));
    send_query(triangle(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_query(triangle(ONE, 7 * ONE, -ONE, 3 * ONE, 2 * ONE, ONE, -ONE, ONE, 4 * ONE,
                        ONE, -ONE));
    send_query(triangle(0, HALF, 0, 32'd3, 32'd1, 32'd7, 32'd5, -32'd4, -32'd2,
                        32'd11, -32'd13));
    send_query(triangle(0, 0, 0, QMAX, QMIN, 32'd1, 32'd1, QMAX, QMIN, QMIN, QMAX));

    offsets[0] = 32'h0;
    offsets[1] = QMAX;
    offsets[2] = QMIN;
    offsets[3] = 32'hffff_8000;
    offsets[4] = $urandom;
    offsets[5] = ONE;
    for (p = 0; p < PHASES; p++) begin
      set_height_offset(offsets[p]);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 50 == 0) begin
          calm = ($urandom_range(0, 3) == 0);
        end
        send_query(random_query());
      end
    end

    in_bus.valid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN) @(negedge clk);
    $display("Summary: %0d triangle queries under %0d offset settings (reset value included)",
             sent, offsets_written + 1);
    $display("Summary: %0d height words checked, %0d degenerate, %0d saturated, %0d failures",
             word_count, degenerate_count, saturated_count, fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
